// ===== rtl/mse_pkg.sv =====
// shared constants, types and address helper for the matrix square engine
// no dependencies; used by every module under rtl

package mse_pkg;

    // largest matrix the store holds, and the reach of the 5-bit indices
    localparam int MAX_DIM     = 32;
    localparam int INDEX_REACH = 32;
    localparam int DIM_LIMIT   = (MAX_DIM < INDEX_REACH) ? MAX_DIM : INDEX_REACH;

    localparam int IDX_W   = 5;
    localparam int SIZE_W  = 6;
    localparam int ELEM_W  = 16;
    localparam int PROD_W  = 2 * ELEM_W;
    localparam int ACC_W   = 40;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int ADDR_W  = $clog2(DEPTH);

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 56;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(32);

    // command codes carried on s_tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_ROW  = 1'b1;

    // control that travels down the mac pipeline beside the operands
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

    // sequencer status seen by the top level
    typedef struct packed {
        logic busy;
        logic wait_mac;
    } seq_stat_t;

    // row-major store address, row * MAX_DIM + col
    function automatic logic [ADDR_W-1:0] store_addr(input logic [IDX_W-1:0] r,
                                                     input logic [IDX_W-1:0] c);
        return ADDR_W'(32'(r) * 32'(MAX_DIM) + 32'(c));
    endfunction

endpackage

// ===== rtl/mse_store.sv =====
// matrix element store: one write port, two registered read ports
// depends on mse_pkg for depth and widths

module mse_store (
    input  logic                                 aclk,
    input  logic                                 wr_en,
    input  logic        [mse_pkg::ADDR_W-1:0]    wr_addr,
    input  logic signed [mse_pkg::ELEM_W-1:0]    wr_data,
    input  logic        [mse_pkg::ADDR_W-1:0]    rd_addr_a,
    input  logic        [mse_pkg::ADDR_W-1:0]    rd_addr_b,
    output logic signed [mse_pkg::ELEM_W-1:0]    rd_data_a,
    output logic signed [mse_pkg::ELEM_W-1:0]    rd_data_b
);

    logic signed [mse_pkg::ELEM_W-1:0] mem [mse_pkg::DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ===== rtl/mse_mac.sv =====
// shared multiply-accumulate unit: registered 16x16 product, then 40-bit sum
// depends on mse_pkg for widths and the mac control struct

module mse_mac (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  mse_pkg::mac_ctl_t                    ctl_in,
    input  logic signed [mse_pkg::ELEM_W-1:0]    op_a,
    input  logic signed [mse_pkg::ELEM_W-1:0]    op_b,
    output logic signed [mse_pkg::ACC_W-1:0]     acc,
    output logic                                 done
);

    mse_pkg::mac_ctl_t                  ctl_d1_reg, ctl_d2_reg;
    logic signed [mse_pkg::PROD_W-1:0]  prod_reg;
    logic signed [mse_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic signed [mse_pkg::ACC_W-1:0]   prod_ext;
    logic                               done_reg;

    // operands arrive in the cycle after the issue, beside ctl_d1
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_d1_reg <= '0;
            ctl_d2_reg <= '0;
            done_reg   <= 1'b0;
        end else begin
            ctl_d1_reg <= ctl_in;
            ctl_d2_reg <= ctl_d1_reg;
            done_reg   <= ctl_d2_reg.valid & ctl_d2_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_d1_reg.valid) begin
            prod_reg <= mse_pkg::PROD_W'(op_a) * mse_pkg::PROD_W'(op_b);
        end
    end

    assign prod_ext = {{(mse_pkg::ACC_W - mse_pkg::PROD_W){prod_reg[mse_pkg::PROD_W-1]}},
                       prod_reg};

    always_comb begin
        acc_next = acc_reg;
        if (ctl_d2_reg.valid) begin
            acc_next = ctl_d2_reg.first ? prod_ext : acc_reg + prod_ext;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

// ===== rtl/mse_seq.sv =====
// sequencer: walks column j and term k of one result row through the mac
// depends on mse_pkg for widths, address helper and status types

module mse_seq (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [mse_pkg::IDX_W-1:0]         start_row,
    input  logic [mse_pkg::SIZE_W-1:0]        dim,
    input  logic                              mac_done,
    input  logic                              out_free,
    output logic [mse_pkg::ADDR_W-1:0]        addr_a,
    output logic [mse_pkg::ADDR_W-1:0]        addr_b,
    output mse_pkg::mac_ctl_t                 mac_ctl,
    output logic                              emit,
    output logic [mse_pkg::IDX_W-1:0]         emit_row,
    output logic [mse_pkg::IDX_W-1:0]         emit_col,
    output logic                              emit_last,
    output mse_pkg::seq_stat_t                stat
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic [mse_pkg::IDX_W-1:0]   row_reg;
    logic [mse_pkg::SIZE_W-1:0]  dim_reg;
    logic [mse_pkg::IDX_W-1:0]   j_reg, j_next;
    logic [mse_pkg::IDX_W-1:0]   k_reg, k_next;
    logic                        k_last, j_last;

    assign k_last = ({1'b0, k_reg} == dim_reg - mse_pkg::SIZE_W'(1));
    assign j_last = ({1'b0, j_reg} == dim_reg - mse_pkg::SIZE_W'(1));

    always_comb begin
        state_next = state_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        emit       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_RUN;
                    j_next     = '0;
                    k_next     = '0;
                end
            end
            ST_RUN: begin
                if (k_last) begin
                    state_next = ST_WAIT;
                    k_next     = '0;
                end else begin
                    k_next = k_reg + mse_pkg::IDX_W'(1);
                end
            end
            ST_WAIT: begin
                if (mac_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (j_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_RUN;
                        j_next     = j_reg + mse_pkg::IDX_W'(1);
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            j_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start && state_reg == ST_IDLE) begin
            row_reg <= start_row;
            dim_reg <= dim;
        end
    end

    // a[i][k] and a[k][j]
    assign addr_a = mse_pkg::store_addr(row_reg, k_reg);
    assign addr_b = mse_pkg::store_addr(k_reg, j_reg);

    assign mac_ctl.valid = (state_reg == ST_RUN);
    assign mac_ctl.first = (k_reg == '0);
    assign mac_ctl.last  = k_last;

    assign emit_row  = row_reg;
    assign emit_col  = j_reg;
    assign emit_last = j_last;

    assign stat.busy     = (state_reg != ST_IDLE);
    assign stat.wait_mac = (state_reg == ST_WAIT);

endmodule

// ===== rtl/matrix_square_engine.sv =====
// matrix square engine: loads a matrix element by element and emits rows of a*a
// a load beat is written to the store as it is accepted; a row request of size n is worked
// by one shared multiply-accumulate doing n terms per column, one column after another
// the input side is not ready while a row is being worked; one result beat is
// held in an output register so the next request can be accepted meanwhile
// aresetn is synchronous active low: clears control and sets matrix_size to 32;
// the element store is not cleared and must be loaded before it is read

module matrix_square_engine (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write channel: matrix_size
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mse_pkg::SIZE_W-1:0]        cfg_data,
    // input beats
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mse_pkg::S_DATA_W-1:0]      s_tdata,  // row_index[4:0], col_index[9:5],
                                                        // element_value[25:10], zero pad
    input  logic                              s_tuser,  // cmd
    // result beats
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mse_pkg::M_DATA_W-1:0]      m_tdata,  // result_value[39:0],
                                                        // result_row[44:40],
                                                        // result_col[49:45], zero pad
    output logic                              m_tlast   // last
);

    // configuration register
    logic [mse_pkg::SIZE_W-1:0] size_reg;
    logic [mse_pkg::SIZE_W-1:0] dim;

    // input decode
    logic                              in_beat;
    logic [mse_pkg::IDX_W-1:0]         in_row, in_col;
    logic signed [mse_pkg::ELEM_W-1:0] in_elem;
    logic                              row_ok, load_ok;
    logic                              start, wr_en;

    // store and mac
    logic [mse_pkg::ADDR_W-1:0]        addr_a, addr_b;
    logic signed [mse_pkg::ELEM_W-1:0] rd_a, rd_b;
    mse_pkg::mac_ctl_t                 mac_ctl;
    logic signed [mse_pkg::ACC_W-1:0]  acc;
    logic                              mac_done;

    // sequencer results
    logic                              emit, emit_last, out_free;
    logic [mse_pkg::IDX_W-1:0]         emit_row, emit_col;
    mse_pkg::seq_stat_t                stat;

    // output register
    logic                              out_valid_reg;
    logic signed [mse_pkg::ACC_W-1:0]  out_value_reg;
    logic [mse_pkg::IDX_W-1:0]         out_row_reg, out_col_reg;
    logic                              out_last_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= mse_pkg::SIZE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            size_reg <= cfg_data;
        end
    end

    // active dimension saturates at the store size and the index reach
    assign dim = (32'(size_reg) > mse_pkg::DIM_LIMIT) ?
                 mse_pkg::SIZE_W'(mse_pkg::DIM_LIMIT) : size_reg;

    assign in_row  = s_tdata[4:0];
    assign in_col  = s_tdata[9:5];
    assign in_elem = s_tdata[25:10];

    assign s_tready = !stat.busy;
    assign in_beat  = s_tvalid && s_tready;

    // a row beyond n emits nothing; loads outside the store are dropped
    assign row_ok  = ({1'b0, in_row} < dim);
    assign load_ok = (32'(in_row) < mse_pkg::MAX_DIM) && (32'(in_col) < mse_pkg::MAX_DIM);

    assign start = in_beat && (s_tuser == mse_pkg::CMD_ROW) && row_ok;
    assign wr_en = in_beat && (s_tuser == mse_pkg::CMD_LOAD) && load_ok;

    mse_store u_store (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (mse_pkg::store_addr(in_row, in_col)),
        .wr_data   (in_elem),
        .rd_addr_a (addr_a),
        .rd_addr_b (addr_b),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    mse_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_in  (mac_ctl),
        .op_a    (rd_a),
        .op_b    (rd_b),
        .acc     (acc),
        .done    (mac_done)
    );

    mse_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .start_row (in_row),
        .dim       (dim),
        .mac_done  (mac_done),
        .out_free  (out_free),
        .addr_a    (addr_a),
        .addr_b    (addr_b),
        .mac_ctl   (mac_ctl),
        .emit      (emit),
        .emit_row  (emit_row),
        .emit_col  (emit_col),
        .emit_last (emit_last),
        .stat      (stat)
    );

    // the output register is free when empty or when its beat leaves this cycle
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_value_reg <= acc;
            out_row_reg   <= emit_row;
            out_col_reg   <= emit_col;
            out_last_reg  <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'b0, out_col_reg, out_row_reg, out_value_reg};

    // a result is only loaded into a free output register
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (!out_valid_reg || m_tready))
        else $error("result loaded over a pending beat");

    // the mac finishes a column only while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_done |-> stat.wait_mac)
        else $error("mac result outside wait");

    // an accepted in-range row request closes the input side next cycle
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> !s_tready)
        else $error("input still ready after row request");

    // no store write while a row is being worked
    a_no_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.busy |-> !wr_en)
        else $error("store written during a row");

endmodule

// ===== verif/matrix_square_engine_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for matrix_square_engine: a directed table of beats, then
// random load and row-request beats, every result beat checked against a local predictor
// depends on rtl/mse_pkg.sv and rtl/matrix_square_engine.sv

module matrix_square_engine_tb;

    localparam int RANDOM_BEATS = 210;
    localparam int LONG_HOLD    = 400;
    localparam int SCRIPT_LEN   = 24;
    // top-left block loaded before any row request; no size used below goes past it
    localparam int FILL_DIM     = 12;

    typedef enum logic [1:0] {STEP_CFG, STEP_LOAD, STEP_ROW} step_kind_t;

    // one row of the directed table; value carries the size on a register write
    typedef struct packed {
        step_kind_t                 kind;
        logic [mse_pkg::IDX_W-1:0]  row;
        logic [mse_pkg::IDX_W-1:0]  col;
        logic [mse_pkg::ELEM_W-1:0] value;
        logic                       typed;
        logic [mse_pkg::ACC_W-1:0]  square;
    } script_step_t;

    typedef struct packed {
        logic [mse_pkg::ACC_W-1:0] value;
        logic [mse_pkg::IDX_W-1:0] row;
        logic [mse_pkg::IDX_W-1:0] col;
        logic                      last;
    } product_t;

    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [mse_pkg::SIZE_W-1:0]   cfg_data;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [mse_pkg::S_DATA_W-1:0] s_tdata;   // row_index, col_index, element_value, zero pad
    logic                         s_tuser;   // cmd
    logic                         m_tvalid;
    logic                         m_tready;
    logic [mse_pkg::M_DATA_W-1:0] m_tdata;   // result_value, result_row, result_col, zero pad
    logic                         m_tlast;   // last

    // shadow copy of the element store and the size register
    logic signed [mse_pkg::ELEM_W-1:0] shadow [mse_pkg::MAX_DIM][mse_pkg::MAX_DIM];
    logic [mse_pkg::SIZE_W-1:0]        shadow_size;
    product_t                          awaited[$];
    int                                fail_count   = 0;
    int                                beats_sent   = 0;
    bit                                steady       = 1'b0;
    bit                                hold_request = 1'b0;

    // typed squares only on one-element matrices, where the result is just a*a
    script_step_t script [SCRIPT_LEN] = '{
        '{STEP_CFG,  5'd0,  5'd0,  16'd1,    1'b0, 40'h0},
        '{STEP_LOAD, 5'd0,  5'd0,  16'h8000, 1'b0, 40'h0},
        '{STEP_ROW,  5'd0,  5'd0,  16'h0000, 1'b1, 40'h00_4000_0000}, // most negative squared
        '{STEP_ROW,  5'd1,  5'd0,  16'h0000, 1'b0, 40'h0},           // row out of range
        '{STEP_ROW,  5'd31, 5'd0,  16'h0000, 1'b0, 40'h0},
        '{STEP_LOAD, 5'd0,  5'd0,  16'h7fff, 1'b0, 40'h0},
        '{STEP_ROW,  5'd0,  5'd0,  16'h0000, 1'b1, 40'h00_3fff_0001}, // most positive squared
        '{STEP_LOAD, 5'd31, 5'd31, 16'h8001, 1'b0, 40'h0},           // stored beyond n
        '{STEP_LOAD, 5'd0,  5'd31, 16'h7fff, 1'b0, 40'h0},
        '{STEP_CFG,  5'd0,  5'd0,  16'd0,    1'b0, 40'h0},           // size zero
        '{STEP_ROW,  5'd0,  5'd0,  16'h0000, 1'b0, 40'h0},
        '{STEP_ROW,  5'd31, 5'd0,  16'h0000, 1'b0, 40'h0},
        '{STEP_CFG,  5'd0,  5'd0,  16'd2,    1'b0, 40'h0},
        '{STEP_LOAD, 5'd0,  5'd1,  16'hffff, 1'b0, 40'h0},
        '{STEP_LOAD, 5'd1,  5'd0,  16'h0100, 1'b0, 40'h0},
        '{STEP_LOAD, 5'd1,  5'd1,  16'h8000, 1'b0, 40'h0},
        '{STEP_ROW,  5'd0,  5'd0,  16'h0000, 1'b0, 40'h0},
        '{STEP_ROW,  5'd1,  5'd0,  16'h0000, 1'b0, 40'h0},
        '{STEP_CFG,  5'd0,  5'd0,  16'd12,   1'b0, 40'h0},           // whole loaded block
        '{STEP_LOAD, 5'd11, 5'd11, 16'h8000, 1'b0, 40'h0},
        '{STEP_LOAD, 5'd11, 5'd0,  16'h7fff, 1'b0, 40'h0},
        '{STEP_ROW,  5'd11, 5'd0,  16'h0000, 1'b0, 40'h0},
        '{STEP_ROW,  5'd0,  5'd0,  16'h0000, 1'b0, 40'h0},
        '{STEP_ROW,  5'd12, 5'd0,  16'h0000, 1'b0, 40'h0}            // first row past n
    };

    matrix_square_engine uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [mse_pkg::ELEM_W-1:0] pick_element();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'h8000;
        if (r < 20) return 16'h7fff;
        if (r < 25) return '0;
        return mse_pkg::ELEM_W'($urandom);
    endfunction

    // sizes stay within the loaded block
    function automatic logic [mse_pkg::SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)  return '0;
        if (r < 70) return mse_pkg::SIZE_W'($urandom_range(1, 6));
        return mse_pkg::SIZE_W'($urandom_range(7, FILL_DIM));
    endfunction

    // working dimension: the register value capped at what the store and indices reach
    function automatic int live_dim();
        return (int'(shadow_size) > mse_pkg::DIM_LIMIT) ? mse_pkg::DIM_LIMIT
                                                        : int'(shadow_size);
    endfunction

    // one row of a*a over the shadow store, queued as the awaited result beats
    task automatic square_row(input logic [mse_pkg::IDX_W-1:0] r);
        int       n;
        longint   acc;
        product_t p;
        n = live_dim();
        if (int'(r) >= n) return;
        for (int j = 0; j < n; j++) begin
            acc = 0;
            for (int k = 0; k < n; k++)
                acc += longint'(shadow[r][k]) * longint'(shadow[k][j]);
            p.value = acc[mse_pkg::ACC_W-1:0];
            p.row   = r;
            p.col   = mse_pkg::IDX_W'(j);
            p.last  = (j == n - 1);
            awaited.push_back(p);
        end
    endtask

    task automatic send_beat(input logic cmd, input logic [mse_pkg::IDX_W-1:0] r,
                             input logic [mse_pkg::IDX_W-1:0] c,
                             input logic [mse_pkg::ELEM_W-1:0] v,
                             input logic typed, input logic [mse_pkg::ACC_W-1:0] square);
        int gap;
        gap = steady ? 0 : idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= mse_pkg::S_DATA_W'({v, c, r});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (cmd == mse_pkg::CMD_LOAD) begin
            shadow[r][c] = v;
        end else if (typed) begin
            awaited.push_back(product_t'{square, r, mse_pkg::IDX_W'(0), 1'b1});
        end else begin
            square_row(r);
        end
        beats_sent++;
    endtask

    task automatic write_size(input logic [mse_pkg::SIZE_W-1:0] size);
        cfg_valid <= 1'b1;
        cfg_data  <= size;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid   <= 1'b0;
        shadow_size = size;
    endtask

    // drain every awaited beat, then give a silent row request time to finish
    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaited.size() != 0) @(posedge aclk);
        repeat (live_dim() * (live_dim() + 4) + 16) @(posedge aclk);
    endtask

    initial begin : stimulus
        int                        n;
        int                        per;
        int                        pick;
        int                        load_pct;
        int                        phase;
        int                        first_random;
        logic [mse_pkg::IDX_W-1:0] r;
        logic [mse_pkg::IDX_W-1:0] c;
        script_step_t              st;

        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= mse_pkg::CMD_LOAD;
        shadow_size = mse_pkg::SIZE_RESET;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // the store is undefined until written, so fill the block every size below reaches
        for (int i = 0; i < FILL_DIM * FILL_DIM; i++)
            send_beat(mse_pkg::CMD_LOAD, mse_pkg::IDX_W'(i / FILL_DIM),
                      mse_pkg::IDX_W'(i % FILL_DIM), pick_element(), 1'b0, '0);

        for (int i = 0; i < SCRIPT_LEN; i++) begin
            st = script[i];
            case (st.kind)
                STEP_CFG: begin
                    quiesce();
                    write_size(st.value[mse_pkg::SIZE_W-1:0]);
                end
                STEP_LOAD: send_beat(mse_pkg::CMD_LOAD, st.row, st.col, st.value, 1'b0, '0);
                default:   send_beat(mse_pkg::CMD_ROW, st.row, mse_pkg::IDX_W'($urandom),
                                     mse_pkg::ELEM_W'($urandom), st.typed, st.square);
            endcase
        end

        // random phases, each under its own size setting
        phase        = 0;
        first_random = beats_sent;
        while (beats_sent - first_random < RANDOM_BEATS) begin
            quiesce();
            steady   = ($urandom_range(0, 3) == 0);
            load_pct = 50;
            if (phase == 1) begin
                // result side holds off while row requests pile up behind it
                steady       = 1'b0;
                load_pct     = 10;
                hold_request = 1'b1;
                write_size(mse_pkg::SIZE_W'(4));
            end else begin
                write_size(pick_size());
            end
            n   = live_dim();
            per = (n > 16) ? 10 : 36;
            for (int b = 0; b < per; b++) begin
                pick = $urandom_range(0, 99);
                if (pick < load_pct) begin
                    if (n > 0 && $urandom_range(0, 4) != 0) begin
                        r = mse_pkg::IDX_W'($urandom_range(0, n - 1));
                        c = mse_pkg::IDX_W'($urandom_range(0, n - 1));
                    end else begin
                        r = mse_pkg::IDX_W'($urandom);
                        c = mse_pkg::IDX_W'($urandom);
                    end
                    send_beat(mse_pkg::CMD_LOAD, r, c, pick_element(), 1'b0, '0);
                end else begin
                    if (n > 0 && pick < 93) r = mse_pkg::IDX_W'($urandom_range(0, n - 1));
                    else                    r = mse_pkg::IDX_W'($urandom);
                    send_beat(mse_pkg::CMD_ROW, r, mse_pkg::IDX_W'($urandom),
                              mse_pkg::ELEM_W'($urandom), 1'b0, '0);
                end
            end
            phase++;
        end

        quiesce();
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : result_sink
        int gap;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            gap = steady ? 0 : idle_gap();
            if (hold_request) begin
                hold_request = 1'b0;
                gap += LONG_HOLD;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        product_t got;
        product_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[mse_pkg::ACC_W-1:0],
                    m_tdata[mse_pkg::ACC_W+mse_pkg::IDX_W-1:mse_pkg::ACC_W],
                    m_tdata[mse_pkg::ACC_W+2*mse_pkg::IDX_W-1:mse_pkg::ACC_W+mse_pkg::IDX_W],
                    m_tlast};
            if (awaited.size() == 0) begin
                $error("result beat with none awaited: value %0d row %0d col %0d",
                       $signed(got.value), got.row, got.col);
                fail_count++;
            end else begin
                want = awaited.pop_front();
                if (got.value !== want.value) begin
                    $error("result_value expected %0d got %0d",
                           $signed(want.value), $signed(got.value));
                    fail_count++;
                end
                if (got.row !== want.row) begin
                    $error("result_row expected %0d got %0d", want.row, got.row);
                    fail_count++;
                end
                if (got.col !== want.col) begin
                    $error("result_col expected %0d got %0d", want.col, got.col);
                    fail_count++;
                end
                if (got.last !== want.last) begin
                    $error("last expected %0b got %0b", want.last, got.last);
                    fail_count++;
                end
            end
        end
    end

    initial begin : watchdog
        #(64'd50_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mse_pkg.sv
rtl/mse_store.sv
rtl/mse_mac.sv
rtl/mse_seq.sv
rtl/matrix_square_engine.sv
verif/matrix_square_engine_tb.sv
